>>> src/fcvu_pkg.sv
// Shared constants, types and functions of the fly camera view block.
package fcvu_pkg;

	localparam int TRIG_TABLE_BITS = 10;
	localparam int QUARTER         = 1 << (TRIG_TABLE_BITS - 2);
	localparam int TURN            = 92160;
	localparam int HALF_TURN       = 46080;
	localparam int PITCH_LIMIT     = 22784;
	localparam int ONE_Q14         = 16384;
	localparam int POLY_A          = 25736;
	localparam int POLY_B          = 10512;
	localparam int POLY_C          = 1160;

	localparam int TURN_LOG = 11;
	localparam int TURN_ODD = TURN >> TURN_LOG;
	localparam int DIV_SH   = TRIG_TABLE_BITS + TURN_LOG;
	localparam int DIV_M    = ((1 << DIV_SH) + TURN_ODD - 1) / TURN_ODD;

	localparam int ANG_W = 17;
	localparam int POS_W = 32;
	localparam int VEC_W = 16;
	localparam int SHF_W = 34;
	localparam int MA_W  = 33;
	localparam int MB_W  = ((TRIG_TABLE_BITS + 7) > 17) ? (TRIG_TABLE_BITS + 7) : 17;
	localparam int PRD_W = MA_W + MB_W;
	localparam int ACC_W = 52;
	localparam int DX_W  = 21;
	localparam int WR_W  = 22;
	localparam int NUM_W = ANG_W + TRIG_TABLE_BITS;
	localparam int QW    = TRIG_TABLE_BITS + 1;
	localparam int CNT_W = $clog2((QW > 9) ? QW : 9);

	localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
	localparam logic [2:0] CFG_LOOK_SENS   = 3'd1;
	localparam logic [2:0] CFG_START_YAW   = 3'd2;
	localparam logic [2:0] CFG_START_PITCH = 3'd3;
	localparam logic [2:0] CFG_START_POS_X = 3'd4;
	localparam logic [2:0] CFG_START_POS_Y = 3'd5;
	localparam logic [2:0] CFG_START_POS_Z = 3'd6;

	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_LOOK = 1'b1;

	localparam logic [1:0] DIR_FORWARD  = 2'd0;
	localparam logic [1:0] DIR_BACKWARD = 2'd1;
	localparam logic [1:0] DIR_LEFT     = 2'd2;
	localparam logic [1:0] DIR_RIGHT    = 2'd3;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [15:0] qtab_t [QUARTER];

	localparam acc_t POS_MAX = ACC_W'(64'sh7FFF_FFFF);
	localparam acc_t POS_MIN = ACC_W'(-64'sh8000_0000);
	localparam acc_t UNIT_MAX = ACC_W'(ONE_Q14);
	localparam acc_t UNIT_MIN = ACC_W'(-ONE_Q14);

	function automatic int qsin_calc(int k);
		longint t, t2, inner, mid;
		t     = longint'(k) << (16 - TRIG_TABLE_BITS);
		t2    = (t * t) >> 14;
		inner = POLY_B - ((POLY_C * t2) >> 14);
		mid   = POLY_A - ((t2 * inner) >> 14);
		return int'((t * mid) >> 14);
	endfunction

	function automatic qtab_t qtab_build();
		qtab_t tab;
		for (int k = 0; k < QUARTER; k++) begin
			tab[k] = 16'(qsin_calc(k));
		end
		return tab;
	endfunction

	localparam qtab_t QSIN_TAB = qtab_build();

	function automatic vec_t table_sin(logic [TRIG_TABLE_BITS-1:0] p);
		logic [1:0]                    q;
		logic [TRIG_TABLE_BITS-2:0]    kk;
		logic [15:0]                   s;
		q = p[TRIG_TABLE_BITS-1 -: 2];
		if (q[0]) begin
			kk = (TRIG_TABLE_BITS-1)'(QUARTER) - {1'b0, p[TRIG_TABLE_BITS-3:0]};
		end else begin
			kk = {1'b0, p[TRIG_TABLE_BITS-3:0]};
		end
		s = kk[TRIG_TABLE_BITS-2] ? 16'(ONE_Q14) : QSIN_TAB[kk[TRIG_TABLE_BITS-3:0]];
		return q[1] ? -vec_t'(s) : vec_t'(s);
	endfunction

	function automatic ang_t wrap_angle(logic signed [WR_W-1:0] a);
		logic [WR_W-1:0] u;
		u = a + WR_W'(HALF_TURN + 8 * TURN);
		for (int j = 3; j >= 0; j--) begin
			if (u >= WR_W'(TURN << j)) begin
				u = u - WR_W'(TURN << j);
			end
		end
		u = u - WR_W'(HALF_TURN);
		return ang_t'(u);
	endfunction

	function automatic logic [NUM_W-1:0] idx_num(ang_t a);
		logic [ANG_W-1:0] u;
		u = (a < 0) ? ANG_W'(a + ang_t'(TURN)) : ANG_W'(a);
		return (NUM_W'(u) << TRIG_TABLE_BITS) + NUM_W'(HALF_TURN);
	endfunction

	function automatic acc_t rnd14(acc_t a);
		acc_t t;
		t = a + ACC_W'(8192) - {{(ACC_W-1){1'b0}}, a[ACC_W-1]};
		return t >>> 14;
	endfunction

	function automatic acc_t rnd12(acc_t a);
		acc_t t;
		t = a + ACC_W'(2048) - {{(ACC_W-1){1'b0}}, a[ACC_W-1]};
		return t >>> 12;
	endfunction

	function automatic vec_t sat_unit(acc_t a);
		if (a > UNIT_MAX) return vec_t'(ONE_Q14);
		if (a < UNIT_MIN) return vec_t'(-ONE_Q14);
		return vec_t'(a);
	endfunction

	function automatic pos_t sat32(acc_t a);
		if (a > POS_MAX) return pos_t'(POS_MAX);
		if (a < POS_MIN) return pos_t'(POS_MIN);
		return pos_t'(a);
	endfunction

endpackage

>>> src/fly_camera_view_update.sv
// Fly camera with Euler angles: position, yaw, pitch and look-at view terms.
// A word after reset or a start angle write first goes through the vector rebuild.
// Throughput: one word at a time; the next word is taken the cycle after the result leaves.
// Rate set by the single shared multiplier, also used for the angle-to-index step.
// Reset loads default registers, zero angles and position; vectors rebuild on the first item.
module fly_camera_view_update
	import fcvu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [1:0]         move_dir,
	input  logic [15:0]        elapsed_time,
	input  logic signed [15:0] offset_x,
	input  logic signed [15:0] offset_y,
	input  logic               clamp_pitch,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z,
	output logic signed [15:0] upvec_x,
	output logic signed [15:0] upvec_y,
	output logic signed [15:0] upvec_z,
	output logic signed [15:0] back_x,
	output logic signed [15:0] back_y,
	output logic signed [15:0] back_z,
	output logic signed [33:0] shift_x,
	output logic signed [33:0] shift_y,
	output logic signed [33:0] shift_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MOVE = 9'b000000010,
		ST_LOOK = 9'b000000100,
		ST_PREP = 9'b000001000,
		ST_DIV  = 9'b000010000,
		ST_TRIG = 9'b000100000,
		ST_VEC  = 9'b001000000,
		ST_DOT  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic   ph_q;
	logic [CNT_W-1:0] cnt_q;
	logic   dirty_q, pend_q, keep_q;

	logic        op_q, clamp_q;
	logic [1:0]  dir_q;
	logic [15:0] et_q;
	logic signed [15:0] ox_q, oy_q;

	logic [15:0] speed_q, sens_q;
	ang_t  yaw_q, pitch_q;
	pos_t  pos_q [3];
	vec_t  front_q [3];
	vec_t  right_q [3];
	vec_t  up_q [3];
	logic [23:0] v_q;
	logic signed [DX_W-1:0] dx_q;
	acc_t  acc_q;
	logic [NUM_W-1:0] numy_q, nump_q;
	logic [QW-1:0] qy_q, qp_q;
	vec_t  sy_q, cy_q, sp_q, cp_q;
	logic signed [SHF_W-1:0] shf_q [3];

	logic signed [MA_W-1:0]  ma;
	logic signed [MB_W-1:0]  mb;
	logic signed [PRD_W-1:0] prod_q;
	acc_t  pe;
	logic [1:0] mi, drow, dcol;
	vec_t  mvec, dvec;

	fcvu_mul u_mul (
		.clk    (clk),
		.a      (ma),
		.b      (mb),
		.prod_q (prod_q)
	);

	assign pe = ACC_W'(prod_q);
	assign mi = cnt_q[1:0] - 2'd1;

	always_comb begin
		unique case (cnt_q)
			CNT_W'(0): begin drow = 2'd0; dcol = 2'd0; end
			CNT_W'(1): begin drow = 2'd0; dcol = 2'd1; end
			CNT_W'(2): begin drow = 2'd0; dcol = 2'd2; end
			CNT_W'(3): begin drow = 2'd1; dcol = 2'd0; end
			CNT_W'(4): begin drow = 2'd1; dcol = 2'd1; end
			CNT_W'(5): begin drow = 2'd1; dcol = 2'd2; end
			CNT_W'(6): begin drow = 2'd2; dcol = 2'd0; end
			CNT_W'(7): begin drow = 2'd2; dcol = 2'd1; end
			CNT_W'(8): begin drow = 2'd2; dcol = 2'd2; end
			default:   begin drow = 2'd0; dcol = 2'd0; end
		endcase
	end

	always_comb begin
		mvec = (dir_q == DIR_FORWARD || dir_q == DIR_BACKWARD) ? front_q[mi] : right_q[mi];
		unique case (drow)
			2'd0:    dvec = right_q[dcol];
			2'd1:    dvec = up_q[dcol];
			default: dvec = front_q[dcol];
		endcase
	end

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_MOVE: begin
				if (cnt_q == '0) begin
					ma = MA_W'(speed_q);
					mb = MB_W'(et_q);
				end else begin
					ma = MA_W'(v_q);
					mb = MB_W'(mvec);
				end
			end
			ST_LOOK: begin
				ma = MA_W'(sens_q);
				mb = (cnt_q == '0) ? MB_W'(ox_q) : MB_W'(oy_q);
			end
			ST_DIV: begin
				ma = MA_W'(DIV_M);
				mb = (cnt_q == '0) ? MB_W'(numy_q >> TURN_LOG) : MB_W'(nump_q >> TURN_LOG);
			end
			ST_VEC: begin
				unique case (cnt_q)
					CNT_W'(0): begin ma = MA_W'(cy_q);       mb = MB_W'(cp_q);       end
					CNT_W'(1): begin ma = MA_W'(sy_q);       mb = MB_W'(cp_q);       end
					CNT_W'(2): begin ma = MA_W'(right_q[2]); mb = MB_W'(front_q[1]); end
					CNT_W'(3): begin ma = MA_W'(right_q[2]); mb = MB_W'(front_q[0]); end
					CNT_W'(4): begin ma = MA_W'(right_q[0]); mb = MB_W'(front_q[2]); end
					default:   begin ma = MA_W'(right_q[0]); mb = MB_W'(front_q[1]); end
				endcase
			end
			ST_DOT: begin
				ma = MA_W'(pos_q[dcol]);
				mb = MB_W'(dvec);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		acc_t d, s, r;
		logic signed [WR_W-1:0] np;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= 1'b0;
			cnt_q   <= '0;
			dirty_q <= 1'b1;
			pend_q  <= 1'b0;
			keep_q  <= 1'b0;
			speed_q <= 16'd640;
			sens_q  <= 16'd6554;
			yaw_q   <= '0;
			pitch_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MOVE_SPEED:  speed_q <= cfg_data[15:0];
					CFG_LOOK_SENS:   sens_q  <= cfg_data[15:0];
					CFG_START_YAW: begin
						yaw_q   <= wrap_angle(WR_W'(ang_t'(cfg_data[16:0])));
						dirty_q <= 1'b1;
					end
					CFG_START_PITCH: begin
						pitch_q <= wrap_angle(WR_W'(ang_t'(cfg_data[16:0])));
						dirty_q <= 1'b1;
					end
					CFG_START_POS_X: pos_q[0] <= pos_t'(cfg_data);
					CFG_START_POS_Y: pos_q[1] <= pos_t'(cfg_data);
					CFG_START_POS_Z: pos_q[2] <= pos_t'(cfg_data);
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						dir_q   <= move_dir;
						et_q    <= elapsed_time;
						ox_q    <= offset_x;
						oy_q    <= offset_y;
						clamp_q <= clamp_pitch;
						cnt_q   <= '0;
						ph_q    <= 1'b0;
						if (dirty_q) begin
							dirty_q <= 1'b0;
							pend_q  <= 1'b1;
							keep_q  <= 1'b0;
							state_q <= ST_PREP;
						end else begin
							state_q <= (op == OP_LOOK) ? ST_LOOK : ST_MOVE;
						end
					end
				end
				ST_MOVE: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == '0) begin
							v_q <= pe[31:8];
						end else begin
							d = rnd14(pe);
							if (dir_q == DIR_BACKWARD || dir_q == DIR_LEFT) begin
								d = -d;
							end
							pos_q[mi] <= sat32(ACC_W'(pos_q[mi]) + d);
							if (cnt_q == CNT_W'(3)) begin
								cnt_q   <= '0;
								state_q <= ST_DOT;
							end
						end
					end
				end
				ST_LOOK: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == '0) begin
							dx_q <= DX_W'(rnd12(pe));
						end else begin
							d = rnd12(pe);
							yaw_q <= wrap_angle(WR_W'(yaw_q) + WR_W'(dx_q));
							np = WR_W'(pitch_q) + WR_W'(d);
							if (clamp_q) begin
								if (np > WR_W'(PITCH_LIMIT)) begin
									pitch_q <= ang_t'(PITCH_LIMIT);
								end else if (np < WR_W'(-PITCH_LIMIT)) begin
									pitch_q <= ang_t'(-PITCH_LIMIT);
								end else begin
									pitch_q <= ang_t'(np);
								end
							end else begin
								pitch_q <= wrap_angle(np);
							end
							keep_q  <= 1'b1;
							cnt_q   <= '0;
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					numy_q  <= idx_num(yaw_q);
					nump_q  <= idx_num(pitch_q);
					qy_q    <= '0;
					qp_q    <= '0;
					cnt_q   <= '0;
					ph_q    <= 1'b0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == '0) begin
							qy_q <= QW'(pe >>> DIV_SH);
						end else begin
							qp_q    <= QW'(pe >>> DIV_SH);
							cnt_q   <= '0;
							state_q <= ST_TRIG;
						end
					end
				end
				ST_TRIG: begin
					sy_q <= table_sin(qy_q[TRIG_TABLE_BITS-1:0]);
					cy_q <= table_sin(qy_q[TRIG_TABLE_BITS-1:0] + TRIG_TABLE_BITS'(QUARTER));
					sp_q <= table_sin(qp_q[TRIG_TABLE_BITS-1:0]);
					cp_q <= table_sin(qp_q[TRIG_TABLE_BITS-1:0] + TRIG_TABLE_BITS'(QUARTER));
					cnt_q   <= '0;
					ph_q    <= 1'b0;
					state_q <= ST_VEC;
				end
				ST_VEC: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
						if (cnt_q == '0) begin
							front_q[1] <= sat_unit(ACC_W'(sp_q));
							if (cp_q < 0) begin
								right_q[0] <= sy_q;
								right_q[1] <= '0;
								right_q[2] <= -cy_q;
							end else if (cp_q > 0 || !keep_q) begin
								right_q[0] <= -sy_q;
								right_q[1] <= '0;
								right_q[2] <= cy_q;
							end
						end
					end else begin
						ph_q  <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						unique case (cnt_q)
							CNT_W'(0): front_q[0] <= sat_unit(rnd14(pe));
							CNT_W'(1): front_q[2] <= sat_unit(rnd14(pe));
							CNT_W'(2): up_q[0]    <= sat_unit(-rnd14(pe));
							CNT_W'(3): acc_q      <= pe;
							CNT_W'(4): up_q[1]    <= sat_unit(rnd14(acc_q - pe));
							default: begin
								up_q[2] <= sat_unit(rnd14(pe));
								cnt_q   <= '0;
								if (pend_q) begin
									pend_q  <= 1'b0;
									state_q <= (op_q == OP_LOOK) ? ST_LOOK : ST_MOVE;
								end else begin
									state_q <= ST_DOT;
								end
							end
						endcase
					end
				end
				ST_DOT: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						s = (dcol == 2'd0) ? pe : acc_q + pe;
						acc_q <= s;
						if (dcol == 2'd2) begin
							r = rnd14(s);
							shf_q[drow] <= (drow == 2'd2) ? SHF_W'(r) : SHF_W'(-r);
						end
						if (cnt_q == CNT_W'(8)) begin
							cnt_q   <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	assign right_x = right_q[0];
	assign right_y = right_q[1];
	assign right_z = right_q[2];
	assign upvec_x = up_q[0];
	assign upvec_y = up_q[1];
	assign upvec_z = up_q[2];
	assign back_x  = -front_q[0];
	assign back_y  = -front_q[1];
	assign back_z  = -front_q[2];
	assign shift_x = shf_q[0];
	assign shift_y = shf_q[1];
	assign shift_z = shf_q[2];

endmodule

>>> src/fcvu_mul.sv
// Shared registered signed multiplier of the fly camera view block.
module fcvu_mul
	import fcvu_pkg::*;
(
	input  logic                    clk,
	input  logic signed [MA_W-1:0]  a,
	input  logic signed [MB_W-1:0]  b,
	output logic signed [PRD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

>>> src/fcvu_chk.sv
// Port checker of the fly camera view block, bound to the top level.
module fcvu_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [33:0] shift_x,
	input logic signed [15:0] right_x
);

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input word accepted while result pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !out_valid))
		else $error("block not busy after input word");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result word repeated");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(shift_x) && $stable(right_x)))
		else $error("stalled result word changed");

endmodule

bind fly_camera_view_update fcvu_chk u_fcvu_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.shift_x   (shift_x),
	.right_x   (right_x)
);
